FILE: rtl/assert_macros.svh
// Assertion macros shared by the signal packer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge, disabled while in reset
`define CSPK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true on a rising clock edge
`define CSPK_NEVER(lbl, expr, msg) \
    `CSPK_ASSERT(lbl, !(expr), msg)
`else
`define CSPK_ASSERT(lbl, prop, msg)
`define CSPK_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/cspk_pkg.sv
// Shared types and constants for the CAN signal packer.
// No dependencies; imported by cspk_patch and can_signal_packer_unit.
package cspk_pkg;

    // Field widths of one input item and one result
    localparam int VALUE_W   = 32;
    localparam int START_W   = 6;
    localparam int LEN_W     = 6;
    localparam int PAYLOAD_W = 64;

    // Default frame size and signal length limit
    localparam int FRAME_BYTES_DEF     = 8;
    localparam int MAX_SIGNAL_BITS_DEF = 32;

    // Byte index of a signal chunk: start byte plus or minus up to four chunks
    localparam int IDX_W = 5;

    // Byte order codes
    localparam logic ORDER_INTEL    = 1'b0;
    localparam logic ORDER_MOTOROLA = 1'b1;

    // One input item
    typedef struct packed {
        logic [VALUE_W-1:0] signal_value;
        logic [START_W-1:0] start_bit;
        logic [LEN_W-1:0]   bit_length;
        logic               motorola_order;
    } item_t;

    // Write mask and data for the frame, plus the out-of-frame flag
    typedef struct packed {
        logic [PAYLOAD_W-1:0] wmask;
        logic [PAYLOAD_W-1:0] wbits;
        logic                 layout_error;
    } patch_t;

endpackage

FILE: rtl/cspk_patch.sv
// Combinational signal placement: turns one item into a byte-wise write mask and data.
// Depends on cspk_pkg.
module cspk_patch #(
    parameter int FRAME_BYTES     = cspk_pkg::FRAME_BYTES_DEF,
    parameter int MAX_SIGNAL_BITS = cspk_pkg::MAX_SIGNAL_BITS_DEF
) (
    input  cspk_pkg::item_t  item,
    output cspk_pkg::patch_t patch
);
    import cspk_pkg::*;

    // First chunk plus enough whole bytes for the longest signal
    localparam int NCHUNK = (MAX_SIGNAL_BITS + 7) / 8 + 1;
    localparam int SW     = NCHUNK * 8;

    logic [LEN_W-1:0]           len_sat;
    logic [MAX_SIGNAL_BITS-1:0] len_mask;
    logic [SW-1:0]              data_str;
    logic [SW-1:0]              mask_str;

    // Clip length, mask the value and shift both to the bit offset in the start byte
    always_comb
    begin
        if (item.bit_length > LEN_W'(MAX_SIGNAL_BITS))
        begin
            len_sat = LEN_W'(MAX_SIGNAL_BITS);
        end
        else
        begin
            len_sat = item.bit_length;
        end
        len_mask = {MAX_SIGNAL_BITS{1'b1}} >> (LEN_W'(MAX_SIGNAL_BITS) - len_sat);
        data_str = SW'(item.signal_value[MAX_SIGNAL_BITS-1:0] & len_mask)
                   << item.start_bit[2:0];
        mask_str = SW'(len_mask) << item.start_bit[2:0];
    end

    // Chunk k goes to byte start+k (Intel) or start-k (Motorola)
    always_comb
    begin
        logic [IDX_W-1:0] tgt;
        logic [7:0]       cm;
        logic [7:0]       cb;
        logic             in_frame;
        patch = '0;
        for (int k = 0; k < NCHUNK; k++)
        begin
            cm = mask_str[8*k +: 8];
            cb = data_str[8*k +: 8];
            if (item.motorola_order == ORDER_MOTOROLA)
            begin
                tgt = IDX_W'(item.start_bit[START_W-1:3]) - IDX_W'(k);
            end
            else
            begin
                tgt = IDX_W'(item.start_bit[START_W-1:3]) + IDX_W'(k);
            end
            // top bit set means the index went below zero
            in_frame = !tgt[IDX_W-1] && (tgt < IDX_W'(FRAME_BYTES));
            if ((|cm) && !in_frame)
            begin
                patch.layout_error = 1'b1;
            end
            for (int b = 0; b < FRAME_BYTES; b++)
            begin
                if (in_frame && (tgt == IDX_W'(b)))
                begin
                    patch.wmask[8*b +: 8] = patch.wmask[8*b +: 8] | cm;
                    patch.wbits[8*b +: 8] = patch.wbits[8*b +: 8] | cb;
                end
            end
        end
    end

endmodule

FILE: rtl/can_signal_packer_unit.sv
// An input transfer is held in the input register, then merged into the result register that drives m_tvalid.
// Throughput: one signal per cycle while the result stream is not stalled; the frame merge from the input
// register into the payload register is a masked write, so back-to-back items see each other.
// A stalled result register holds s_tready low once the input register is also full.
// Reset (rst_n low, asynchronous) clears the frame register to zero and empties both stages.
// Depends on cspk_pkg, cspk_patch and assert_macros.svh.
`include "assert_macros.svh"
module can_signal_packer_unit #(
    parameter int FRAME_BYTES     = cspk_pkg::FRAME_BYTES_DEF,
    parameter int MAX_SIGNAL_BITS = cspk_pkg::MAX_SIGNAL_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // signal_value[31:0], start_bit[37:32], bit_length[43:38], zero pad
    input  logic        s_tuser,   // motorola_order
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // payload[63:0]
    output logic        m_tuser    // layout_error
);
    import cspk_pkg::*;

    localparam int FRAME_BITS = FRAME_BYTES * 8;

    logic                  in_valid_reg;
    item_t                 in_item_reg;
    logic                  out_valid_reg;
    logic [PAYLOAD_W-1:0]  out_payload_reg;
    logic                  out_error_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    patch_t                patch;
    item_t                 s_item;
    logic                  adv;

    // Unpack the input transfer
    always_comb
    begin
        s_item.signal_value   = s_tdata[31:0];
        s_item.start_bit      = s_tdata[37:32];
        s_item.bit_length     = s_tdata[43:38];
        s_item.motorola_order = s_tuser;
    end

    // Handshake: the merge stage moves when the result register is free or being taken
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= s_item;
        end
    end

    // Byte placement
    cspk_patch #(
        .FRAME_BYTES     (FRAME_BYTES),
        .MAX_SIGNAL_BITS (MAX_SIGNAL_BITS)
    ) u_patch (
        .item  (in_item_reg),
        .patch (patch)
    );

    // Masked merge into the frame
    assign frame_next = (frame_reg & ~patch.wmask[FRAME_BITS-1:0])
                      | (patch.wbits[FRAME_BITS-1:0] & patch.wmask[FRAME_BITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (adv)
        begin
            frame_reg <= frame_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_payload_reg <= PAYLOAD_W'(frame_next);
            out_error_reg   <= patch.layout_error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_payload_reg;
    assign m_tuser  = out_error_reg;

    // Checks
    `CSPK_ASSERT(a_adv_fills_out, adv |=> out_valid_reg, "merge did not load the result register")
    `CSPK_ASSERT(a_frame_hold, !adv |=> $stable(frame_reg), "frame changed without a merge")
    `CSPK_ASSERT(a_frame_unmasked,
        adv |=> (((frame_reg ^ $past(frame_reg)) & ~$past(patch.wmask[FRAME_BITS-1:0])) == '0),
        "frame bit outside the signal changed")
    `CSPK_NEVER(a_stall_empty, !s_tready && !in_valid_reg, "input stalled with an empty input register")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for can_signal_packer_unit: patches signals into the frame
// payload and checks every returned payload and error flag. Depends on cspk_pkg.
module tb;
    import cspk_pkg::*;

    localparam int FRAME_BYTES     = FRAME_BYTES_DEF;
    localparam int MAX_SIGNAL_BITS = MAX_SIGNAL_BITS_DEF;
    localparam int RANDOM_ITEMS    = 500;
    localparam int IDLE_LIMIT      = 2000;
    localparam int REPORT_LIMIT    = 10;

    // Returned payload with its flag
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic                 layout_error;
    } frame_result_t;

    // One row of the directed table; fixed_result is used only when has_fixed is set
    typedef struct packed {
        item_t         item;
        logic          has_fixed;
        frame_result_t fixed_result;
    } signal_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // signal_value[31:0], start_bit[37:32], bit_length[43:38], zero pad
    logic        s_tuser;    // motorola_order
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // payload[63:0]
    logic        m_tuser;    // layout_error

    // Shadow copy of the frame and the payloads still owed by the block
    logic [7:0]    frame_bytes [0:FRAME_BYTES-1];
    frame_result_t pending_payloads [$];

    int          mismatch_count   = 0;
    int          idle_cycles      = 0;
    int          burst_left;
    int          ready_phase_left = 0;
    int          ready_mode       = 0;
    int unsigned ready_tick       = 0;
    signal_row_t directed_rows [16];

    can_signal_packer_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock, 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Masked write of one byte; false when the byte lies outside the frame
    function automatic bit merge_frame_byte(input int idx, input logic [7:0] mask,
                                            input logic [7:0] bits);
        if (idx < 0 || idx >= FRAME_BYTES)
            return 1'b0;
        frame_bytes[idx] = (frame_bytes[idx] & ~mask) | (bits & mask);
        return 1'b1;
    endfunction

    // Patch one signal into the shadow frame and return the payload the block should give
    function automatic frame_result_t patch_signal(input item_t it);
        int            len;
        int            offset;
        int            idx;
        int            head_bits;
        int            done;
        int            chunk;
        logic [31:0]   val;
        logic [7:0]    mask;
        logic          err;
        frame_result_t res;
        len    = int'(it.bit_length);
        offset = int'(it.start_bit) % 8;
        idx    = int'(it.start_bit) / 8;
        err    = 1'b0;
        if (len > MAX_SIGNAL_BITS)
            len = MAX_SIGNAL_BITS;
        if (len > 0)
        begin
            val = (len >= 32) ? it.signal_value : (it.signal_value & ((32'h1 << len) - 1));
            // first byte: bits above the start offset
            head_bits = 8 - offset;
            if (head_bits > len)
                head_bits = len;
            mask = (8'hFF >> (8 - head_bits)) << offset;
            if (!merge_frame_byte(idx, mask, 8'(val << offset)))
                err = 1'b1;
            done = head_bits;
            // further bytes, aligned to bit 0, walking up (Intel) or down (Motorola)
            while (done < len)
            begin
                chunk = (len - done >= 8) ? 8 : len - done;
                idx   = (it.motorola_order == ORDER_MOTOROLA) ? idx - 1 : idx + 1;
                mask  = 8'hFF >> (8 - chunk);
                if (!merge_frame_byte(idx, mask, 8'(val >> done)))
                    err = 1'b1;
                done += chunk;
            end
        end
        res.payload = '0;
        for (int i = 0; i < FRAME_BYTES && i < 8; i++)
            res.payload[8*i +: 8] = frame_bytes[i];
        res.layout_error = err;
        return res;
    endfunction

    function automatic signal_row_t make_row(input logic [31:0] value, input logic [5:0] start,
                                             input logic [5:0] len, input logic order,
                                             input logic has_fixed, input logic [63:0] payload,
                                             input logic err);
        signal_row_t row;
        row.item.signal_value         = value;
        row.item.start_bit            = start;
        row.item.bit_length           = len;
        row.item.motorola_order       = order;
        row.has_fixed                 = has_fixed;
        row.fixed_result.payload      = payload;
        row.fixed_result.layout_error = err;
        return row;
    endfunction

    // Random signal: mostly legal lengths, some zero and some overlong
    function automatic item_t random_signal();
        item_t it;
        int    pick;
        pick              = $urandom_range(0, 19);
        it.signal_value   = $urandom;
        it.start_bit      = 6'($urandom_range(0, 63));
        it.motorola_order = 1'($urandom_range(0, 1));
        if (pick == 0)
            it.bit_length = 6'd0;
        else if (pick == 1)
            it.bit_length = 6'($urandom_range(33, 63));
        else if (pick == 2)
            it.bit_length = 6'd32;
        else
            it.bit_length = 6'($urandom_range(1, 32));
        return it;
    endfunction

    // Present one item in bursts with random gaps; record the expected payload on transfer
    task automatic send_signal(input item_t it, input logic has_fixed,
                               input frame_result_t fixed_result);
        int            gap;
        frame_result_t predicted;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, it.bit_length, it.start_bit, it.signal_value};
        s_tuser  <= it.motorola_order;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = patch_signal(it);
        pending_payloads.push_back(has_fixed ? fixed_result : predicted);
    endtask

    // Receiver stalls: phases of always ready, mostly ready, mostly stalled, fixed pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (ready_phase_left == 0)
            begin
                ready_mode       = $urandom_range(0, 3);
                ready_phase_left = $urandom_range(10, 60);
            end
            ready_phase_left--;
            ready_tick++;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (ready_tick % 7 < 4);
            endcase
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_payloads.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: payload %h error %b", m_tdata, m_tuser);
            end
            else
            begin
                frame_result_t want;
                want = pending_payloads.pop_front();
                if (m_tdata !== want.payload || m_tuser !== want.layout_error)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: payload exp %h got %h, error exp %b got %b",
                                 want.payload, m_tdata, want.layout_error, m_tuser);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = 1'b0;
        burst_left       = 0;
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_bytes[i] = 8'h00;

        // fixed rows follow on from reset in this order
        directed_rows[0]  = make_row(32'hFFFF_FFFF, 6'd0,  6'd32, ORDER_INTEL,    1'b1,
                                     64'h0000_0000_FFFF_FFFF, 1'b0);
        directed_rows[1]  = make_row(32'h0000_0000, 6'd0,  6'd32, ORDER_INTEL,    1'b1,
                                     64'h0000_0000_0000_0000, 1'b0);
        directed_rows[2]  = make_row(32'hFFFF_FFFF, 6'd63, 6'd1,  ORDER_MOTOROLA, 1'b1,
                                     64'h8000_0000_0000_0000, 1'b0);
        // top bit of the frame, next byte beyond the end
        directed_rows[3]  = make_row(32'hFFFF_FFFF, 6'd63, 6'd2,  ORDER_INTEL,    1'b1,
                                     64'h8000_0000_0000_0000, 1'b1);
        // byte 0 in Motorola order runs off the bottom
        directed_rows[4]  = make_row(32'hFFFF_FFFF, 6'd0,  6'd16, ORDER_MOTOROLA, 1'b1,
                                     64'h8000_0000_0000_00FF, 1'b1);
        // zero length leaves the frame alone
        directed_rows[5]  = make_row(32'hFFFF_FFFF, 6'd8,  6'd0,  ORDER_INTEL,    1'b1,
                                     64'h8000_0000_0000_00FF, 1'b0);
        // overlong length saturates to 32 bits
        directed_rows[6]  = make_row(32'hFFFF_FFFF, 6'd16, 6'd63, ORDER_INTEL,    1'b1,
                                     64'h8000_FFFF_FFFF_00FF, 1'b0);
        directed_rows[7]  = make_row(32'hA5A5_A5A5, 6'd5,  6'd13, ORDER_INTEL,    1'b0, '0, 1'b0);
        directed_rows[8]  = make_row(32'h1234_5678, 6'd59, 6'd20, ORDER_MOTOROLA, 1'b0, '0, 1'b0);
        directed_rows[9]  = make_row(32'h0000_0000, 6'd60, 6'd32, ORDER_MOTOROLA, 1'b0, '0, 1'b0);
        directed_rows[10] = make_row(32'hDEAD_BEEF, 6'd7,  6'd32, ORDER_INTEL,    1'b0, '0, 1'b0);
        directed_rows[11] = make_row(32'h0000_0003, 6'd63, 6'd40, ORDER_MOTOROLA, 1'b0, '0, 1'b0);
        directed_rows[12] = make_row(32'hFFFF_FFFF, 6'd0,  6'd1,  ORDER_INTEL,    1'b0, '0, 1'b0);
        directed_rows[13] = make_row(32'h0000_0000, 6'd32, 6'd33, ORDER_INTEL,    1'b0, '0, 1'b0);
        directed_rows[14] = make_row(32'h0000_5555, 6'd3,  6'd3,  ORDER_MOTOROLA, 1'b0, '0, 1'b0);
        directed_rows[15] = make_row(32'hFFFF_FFFF, 6'd31, 6'd32, ORDER_MOTOROLA, 1'b0, '0, 1'b0);

        // hold reset, then release it on a falling edge
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_signal(directed_rows[i].item, directed_rows[i].has_fixed,
                        directed_rows[i].fixed_result);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_signal(random_signal(), 1'b0, '0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;

        // drain, then wait for stray results
        while (pending_payloads.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && pending_payloads.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cspk_pkg.sv
rtl/cspk_patch.sv
rtl/can_signal_packer_unit.sv
sim/tb.sv
